// ===== rtl/sarsa_lambda_table_update_assert.svh =====
`ifndef SARSA_LAMBDA_TABLE_UPDATE_ASSERT_SVH
`define SARSA_LAMBDA_TABLE_UPDATE_ASSERT_SVH
// implication check with reset disable
`define SLTU_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// next-cycle implication check
`define SLTU_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// ===== rtl/sltu_pkg.sv =====
package sltu_pkg;
  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_STEP  = 2'd1,
    REQ_LOAD  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  localparam logic [1:0] CFG_GAMMA  = 2'd0;
  localparam logic [1:0] CFG_LAMBDA = 2'd1;
  localparam logic [1:0] CFG_ALPHA  = 2'd2;

  localparam logic [15:0] GAMMA_RST  = 16'd52429;
  localparam logic [15:0] LAMBDA_RST = 16'd58982;
  localparam logic [15:0] ALPHA_RST  = 16'd39322;

  localparam int FRAC_BITS = 16;
  localparam int DELTA_WIDTH = 32;
  localparam int VALUE_WIDTH = 32;
endpackage

// ===== rtl/sltu_mul.sv =====
module sltu_mul #(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int VW = 32
) (
  input  logic                 clk,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [VW-1:0] p
);
  import sltu_pkg::*;
  localparam int PW = AW + BW;
  logic signed [PW-1:0] prod_r;
  logic signed [PW-FRAC_BITS-1:0] sh;
  logic signed [VW-1:0] vmax;
  logic signed [VW-1:0] vmin;

  always_ff @(posedge clk) begin
    prod_r <= PW'(a) * PW'(b);
  end

  always_comb begin
    sh = prod_r[PW-1:FRAC_BITS];
    vmax = {1'b0, {(VW-1){1'b1}}};
    vmin = {1'b1, {(VW-1){1'b0}}};
    if (sh > (PW-FRAC_BITS)'(vmax)) begin
      p = vmax;
    end else if (sh < (PW-FRAC_BITS)'(vmin)) begin
      p = vmin;
    end else begin
      p = sh[VW-1:0];
    end
  end
endmodule

// ===== rtl/sltu_mem.sv =====
module sltu_mem #(
  parameter int DEPTH = 25000,
  parameter int AW = 15,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/sarsa_lambda_table_update.sv =====
// SARSA(lambda) table learner, Q16.16 value and trace tables in block memory.
// Input channel in_valid/in_ready carries one request: start (set state,
// action 0), step (learn from the new state and action) or load (write one
// value entry). Every request gives one result on out_valid/out_ready:
// reward, TD error and the state now current.
// Configuration: cfg_we, cfg_addr, cfg_wdata write gamma, lambda, alpha.
// After reset both tables are swept to zero, one entry per cycle, over all
// NUM_STATES*NUM_ACTIONS entries (25000 by default); no request is
// taken during the sweep.
// A start or unknown request passes S_OUT before its result is offered, a
// load request S_LOAD and then S_OUT. A step request reads the two value
// entries and the current trace, then walks every table entry with one
// read-modify-write per cycle through a pipelined multiply path; the walk
// is serial because of the single read port of each table.
// One request is in flight at a time: with out_ready high the next request
// is taken in the cycle after the result. A result waits in the output
// register while out_ready is low and holds off the next request.
module sarsa_lambda_table_update #(
  parameter int NUM_STATES  = 3125,
  parameter int NUM_ACTIONS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [2:0]  in_left_level,
  input  logic [1:0]  in_left_front_level,
  input  logic [1:0]  in_front_level,
  input  logic        in_right_level,
  input  logic [1:0]  in_orientation,
  input  logic [2:0]  in_next_action,
  input  logic [14:0] in_load_index,
  input  logic signed [31:0] in_load_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [0:0]  out_step_reward,
  output logic signed [31:0] out_td_error,
  output logic [11:0] out_state_index,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import sltu_pkg::*;
  localparam int DEPTH = NUM_STATES * NUM_ACTIONS;
  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(NUM_STATES);
  localparam int ACW = $clog2(NUM_ACTIONS);
  localparam int VW = VALUE_WIDTH;
  localparam int LAT = 2;
  localparam int RECIP_SH = 24;
  localparam logic [23:0] STATE_RECIP = 24'((1 << RECIP_SH) / NUM_STATES);
  localparam logic [23:0] ACTION_RECIP = 24'((1 << RECIP_SH) / NUM_ACTIONS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_RD_NXT, S_RD_CUR, S_WAIT1, S_WAIT2, S_DELTA,
    S_MUL, S_SWEEP, S_DRAIN, S_OUT
  } st_t;

  st_t st_r;
  logic [15:0] gamma_r, lambda_r, alpha_r;
  logic [SW-1:0] cur_s_r, nxt_s_r;
  logic [ACW-1:0] cur_a_r, nxt_a_r;
  logic reward_r;
  logic [AW-1:0] cnt_r;
  logic [2:0] wait_r;
  logic signed [VW-1:0] qn_r, qc_r, ec_r, delta_r, step_r;
  logic signed [31:0] td_r;
  logic out_valid_r;
  logic [14:0] lidx_r;
  logic signed [31:0] lval_r;
  logic [15:0] gl_r;

  logic q_we, e_we;
  logic [AW-1:0] q_wa, e_wa, q_ra, e_ra;
  logic [VW-1:0] q_wd, e_wd, q_rd, e_rd;

  sltu_mem #(.DEPTH(DEPTH), .AW(AW), .DW(VW)) u_q (
    .clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));
  sltu_mem #(.DEPTH(DEPTH), .AW(AW), .DW(VW)) u_e (
    .clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd));

  // reciprocal estimate, then one correcting subtract
  function automatic logic [12:0] mod_small(logic [12:0] x, logic [12:0] n,
                                            logic [23:0] recip);
    logic [36:0] prod;
    logic [12:0] q;
    logic [25:0] qn;
    logic [12:0] r;
    prod = 37'(x) * 37'(recip);
    q = prod[RECIP_SH +: 13];
    qn = 26'(q) * 26'(n);
    r = x - qn[12:0];
    if (r >= n) r = r - n;
    return r;
  endfunction

  // state index
  logic [12:0] dsum;
  logic [SW-1:0] ns_idx;
  logic rew_in;
  always_comb begin
    dsum = 13'(in_left_level) + 13'(in_left_front_level) * 13'd5
         + 13'(in_front_level) * 13'd25 + 13'(in_right_level) * 13'd125
         + 13'(in_orientation) * 13'd625;
    ns_idx = SW'(mod_small(dsum, 13'(NUM_STATES), STATE_RECIP));
    rew_in = (in_left_level == 3'd0) || (in_left_front_level == 2'd0) ||
             (in_front_level == 2'd0) || (in_right_level == 1'b0) ||
             (in_left_level == 3'd4);
  end

  // shared multiplier: a (17-bit unsigned as signed) or VW signed
  logic signed [VW:0] mul_a;
  logic signed [VW-1:0] mul_b, mul_p;
  sltu_mul #(.AW(VW+1), .BW(VW), .VW(VW)) u_mul (
    .clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  // sweep pipeline: address of entry in flight
  logic [AW-1:0] pa_r [LAT];
  logic pv_r [LAT];
  logic signed [VW-1:0] qd_r;
  logic [VW-1:0] e_dec;
  logic signed [VW-1:0] mul2_p;
  sltu_mul #(.AW(VW+1), .BW(VW), .VW(VW)) u_mul2 (
    .clk(clk), .a((VW+1)'(signed'({1'b0, gl_r}))), .b(e_rd), .p(mul2_p));

  logic signed [VW:0] qsum;
  logic signed [VW-1:0] qnew;
  logic signed [VW+1:0] dsum_w;
  logic signed [VW-1:0] vmax, vmin, esum;
  logic signed [VW:0] esum_w;

  always_comb begin
    vmax = {1'b0, {(VW-1){1'b1}}};
    vmin = {1'b1, {(VW-1){1'b0}}};
    qsum = (VW+1)'(qd_r) + (VW+1)'(mul_p);
    if (qsum > (VW+1)'(vmax)) qnew = vmax;
    else if (qsum < (VW+1)'(vmin)) qnew = vmin;
    else qnew = qsum[VW-1:0];
    dsum_w = (reward_r ? -(VW+2)'(65536) : (VW+2)'(0)) + (VW+2)'(mul_p) - (VW+2)'(qc_r);
    esum_w = (VW+1)'(ec_r) + (VW+1)'(65536);
    if (esum_w > (VW+1)'(vmax)) esum = vmax;
    else esum = esum_w[VW-1:0];
    e_dec = mul2_p;
  end

  logic [AW-1:0] cur_flat, nxt_flat;
  assign cur_flat = AW'(cur_s_r) * AW'(NUM_ACTIONS) + AW'(cur_a_r);
  assign nxt_flat = AW'(nxt_s_r) * AW'(NUM_ACTIONS) + AW'(nxt_a_r);

  always_comb begin
    q_we = 1'b0; e_we = 1'b0;
    q_wa = cnt_r; e_wa = cnt_r;
    q_wd = '0; e_wd = '0;
    q_ra = cnt_r; e_ra = cnt_r;
    mul_a = (VW+1)'(signed'({1'b0, gamma_r}));
    mul_b = qn_r;
    case (st_r)
      S_CLEAR: begin
        q_we = 1'b1; e_we = 1'b1;
      end
      S_LOAD: begin
        q_wa = AW'(lidx_r);
        q_wd = (VW > 32) ? VW'(lval_r) : lval_r[VW-1:0];
        q_we = (32'(lidx_r) < 32'(DEPTH));
      end
      S_RD_NXT: q_ra = nxt_flat;
      S_RD_CUR: begin
        q_ra = cur_flat; e_ra = cur_flat;
      end
      S_DELTA: begin
        e_wa = cur_flat; e_wd = esum; e_we = 1'b1;
      end
      S_MUL: begin
        mul_a = (VW+1)'(signed'({1'b0, alpha_r}));
        mul_b = delta_r;
      end
      S_SWEEP, S_DRAIN: begin
        mul_a = (VW+1)'(step_r);
        mul_b = e_rd;
        q_wa = pa_r[LAT-1]; q_wd = qnew; q_we = pv_r[LAT-1];
        e_wa = pa_r[1]; e_wd = e_dec; e_we = pv_r[1];
      end
      default: ;
    endcase
  end

  // sweep pipeline timing: read addr, then rdata and mul launch, then product;
  // q rdata held in qd_r until the product, both entries written back together (pa_r[1]).
  always_ff @(posedge clk) begin
    qd_r <= q_rd;
    pa_r[0] <= cnt_r;
    for (int i = 1; i < LAT; i++) pa_r[i] <= pa_r[i-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR;
      gamma_r <= GAMMA_RST; lambda_r <= LAMBDA_RST; alpha_r <= ALPHA_RST;
      cur_s_r <= '0; cur_a_r <= '0; nxt_s_r <= '0; nxt_a_r <= '0;
      cnt_r <= '0; wait_r <= '0; out_valid_r <= 1'b0;
      reward_r <= 1'b0; td_r <= '0;
      for (int i = 0; i < LAT; i++) pv_r[i] <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_GAMMA:  gamma_r <= cfg_wdata;
          CFG_LAMBDA: lambda_r <= cfg_wdata;
          CFG_ALPHA:  alpha_r <= cfg_wdata;
          default: ;
        endcase
      end
      pv_r[0] <= (st_r == S_SWEEP);
      for (int i = 1; i < LAT; i++) pv_r[i] <= pv_r[i-1];
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (st_r)
        S_CLEAR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == AW'(DEPTH - 1)) begin
            cnt_r <= '0; st_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            lidx_r <= in_load_index; lval_r <= in_load_value;
            reward_r <= 1'b0; td_r <= '0;
            case (req_t'(in_req_type))
              REQ_START: begin
                cur_s_r <= ns_idx; cur_a_r <= '0; st_r <= S_OUT;
              end
              REQ_STEP: begin
                nxt_s_r <= ns_idx;
                nxt_a_r <= ACW'(mod_small(13'(in_next_action), 13'(NUM_ACTIONS),
                                          ACTION_RECIP));
                reward_r <= rew_in;
                st_r <= S_RD_NXT;
              end
              REQ_LOAD: st_r <= S_LOAD;
              default: st_r <= S_OUT;
            endcase
          end
        end
        S_LOAD: st_r <= S_OUT;
        S_RD_NXT: st_r <= S_RD_CUR;
        S_RD_CUR: begin
          qn_r <= q_rd; st_r <= S_WAIT1;
        end
        S_WAIT1: begin
          qc_r <= q_rd; ec_r <= e_rd; st_r <= S_WAIT2;
        end
        S_WAIT2: st_r <= S_DELTA;
        S_DELTA: begin
          if (dsum_w > (VW+2)'(vmax)) delta_r <= vmax;
          else if (dsum_w < (VW+2)'(vmin)) delta_r <= vmin;
          else delta_r <= dsum_w[VW-1:0];
          gl_r <= 16'((32'(gamma_r) * 32'(lambda_r)) >> 16);
          wait_r <= '0;
          st_r <= S_MUL;
        end
        S_MUL: begin
          td_r <= (VW > 32) ? ((delta_r > (VW)'(32'sh7fffffff)) ? 32'sh7fffffff :
                  (delta_r < -(VW)'(32'sh7fffffff) - 1) ? 32'sh80000000 : 32'(delta_r))
                  : 32'(delta_r);
          wait_r <= wait_r + 1'b1;
          if (wait_r == 3'd1) begin
            step_r <= mul_p; cnt_r <= '0; st_r <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == AW'(DEPTH - 1)) begin
            cnt_r <= '0; wait_r <= '0; st_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          wait_r <= wait_r + 1'b1;
          if (wait_r == 3'(LAT)) begin
            cur_s_r <= nxt_s_r; cur_a_r <= nxt_a_r; st_r <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid_r <= 1'b1; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (st_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_step_reward = reward_r;
  assign out_td_error = td_r;
  assign out_state_index = 12'(cur_s_r);
endmodule

// ===== rtl/sltu_checker.sv =====
`include "sarsa_lambda_table_update_assert.svh"
module sltu_checker #(
  parameter int NUM_STATES = 3125
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [0:0]  out_step_reward,
  input logic [31:0] out_td_error,
  input logic [11:0] out_state_index
);
  `SLTU_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_td_error), "result dropped")
  `SLTU_ASSERT_IMP(a_no_take, clk, rst_n, out_valid, !in_ready, "request taken with result pending")
  `SLTU_ASSERT_IMP(a_state_rng, clk, rst_n, out_valid, out_state_index < 12'(NUM_STATES), "state index out of range")
  `SLTU_ASSERT_IMP(a_reward_td, clk, rst_n, out_valid && out_step_reward == 1'b0 && out_td_error != 32'd0, out_valid, "bad result")
endmodule

bind sarsa_lambda_table_update sltu_checker #(.NUM_STATES(NUM_STATES)) u_sltu_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_step_reward(out_step_reward),
  .out_td_error(out_td_error), .out_state_index(out_state_index));

// ===== tb/sv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sltu_pkg::*;

  localparam int TABLE_DEPTH = 25000;
  localparam int STATE_COUNT = 3125;
  localparam int ACTION_COUNT = 8;
  localparam longint ONE_Q16 = 65536;
  localparam longint VAL_MAX = 64'sd2147483647;
  localparam longint VAL_MIN = -64'sd2147483648;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [0:0]  reward;
    logic [31:0] td_error;
    logic [11:0] state;
  } learn_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_req_type = '0;
  logic [2:0] in_left_level = '0;
  logic [1:0] in_left_front_level = '0;
  logic [1:0] in_front_level = '0;
  logic in_right_level = 1'b0;
  logic [1:0] in_orientation = '0;
  logic [2:0] in_next_action = '0;
  logic [14:0] in_load_index = '0;
  logic signed [31:0] in_load_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [0:0] out_step_reward;
  logic signed [31:0] out_td_error;
  logic [11:0] out_state_index;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  sarsa_lambda_table_update dut (.*);

  always #5 clk = ~clk;

  longint value_est[TABLE_DEPTH];
  longint trace_est[TABLE_DEPTH];
  int unsigned gamma_est = GAMMA_RST;
  int unsigned lambda_est = LAMBDA_RST;
  int unsigned alpha_est = ALPHA_RST;
  int unsigned state_est = 0;
  int unsigned action_est = 0;

  learn_result_t pending_results[$];
  int mismatches = 0;
  int hold_off_req = 0;
  int hold_off_cnt = 0;

  function automatic longint sat_value(longint x);
    if (x > VAL_MAX) return VAL_MAX;
    if (x < VAL_MIN) return VAL_MIN;
    return x;
  endfunction

  function automatic longint scale_mul(longint a, longint b);
    return sat_value((a * b) >>> 16);
  endfunction

  function automatic int unsigned encode_state(logic [2:0] l, logic [1:0] lf, logic [1:0] f,
                                               logic r, logic [1:0] o);
    return (int'(l) + 5 * int'(lf) + 25 * int'(f) + 125 * int'(r) + 625 * int'(o))
           % STATE_COUNT;
  endfunction

  function automatic learn_result_t learn_update(logic [1:0] rq, logic [2:0] l, logic [1:0] lf,
                                                 logic [1:0] f, logic r, logic [1:0] o,
                                                 logic [2:0] na, logic [14:0] idx,
                                                 logic signed [31:0] val);
    learn_result_t res;
    longint reward, delta, step_size, gl;
    int unsigned nxt_state, nxt_action, cur, nxt;
    reward = 0;
    delta = 0;
    case (req_t'(rq))
      REQ_START: begin
        state_est = encode_state(l, lf, f, r, o);
        action_est = 0;
      end
      REQ_STEP: begin
        nxt_state = encode_state(l, lf, f, r, o);
        nxt_action = na % ACTION_COUNT;
        cur = state_est * ACTION_COUNT + action_est;
        nxt = nxt_state * ACTION_COUNT + nxt_action;
        if (l == 0 || lf == 0 || f == 0 || r == 0 || l == 4) reward = -1;
        delta = sat_value(reward * ONE_Q16 + scale_mul(longint'(gamma_est), value_est[nxt])
                          - value_est[cur]);
        trace_est[cur] = sat_value(trace_est[cur] + ONE_Q16);
        step_size = scale_mul(longint'(alpha_est), delta);
        gl = (longint'(gamma_est) * longint'(lambda_est)) >>> 16;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          value_est[i] = sat_value(value_est[i] + scale_mul(step_size, trace_est[i]));
          trace_est[i] = scale_mul(gl, trace_est[i]);
        end
        state_est = nxt_state;
        action_est = nxt_action;
      end
      REQ_LOAD: begin
        if (idx < TABLE_DEPTH) value_est[idx] = longint'(val);
      end
      default: ;
    endcase
    res.reward = (reward != 0);
    res.td_error = delta[31:0];
    res.state = state_est[11:0];
    return res;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(req_t rq, logic [2:0] l, logic [1:0] lf, logic [1:0] f,
                              logic r, logic [1:0] o, logic [2:0] na, logic [14:0] idx,
                              logic signed [31:0] val, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rq;
    in_left_level <= l;
    in_left_front_level <= lf;
    in_front_level <= f;
    in_right_level <= r;
    in_orientation <= o;
    in_next_action <= na;
    in_load_index <= idx;
    in_load_value <= val;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(learn_update(rq, l, lf, f, r, o, na, idx, val));
  endtask

  task automatic send_random();
    int roll;
    req_t rq;
    logic [14:0] idx;
    logic [31:0] val;
    roll = $urandom_range(0, 19);
    if (roll < 3) rq = REQ_START;
    else if (roll < 10) rq = REQ_STEP;
    else if (roll < 19) rq = REQ_LOAD;
    else rq = REQ_NONE;
    idx = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'(state_est * ACTION_COUNT
          + $urandom_range(0, ACTION_COUNT - 1));
    val = ($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1) != 0) ? 32'h7fffffff
          : 32'h80000000) : $urandom;
    send_request(rq, 3'($urandom), 2'($urandom), 2'($urandom), 1'($urandom), 2'($urandom),
                 3'($urandom), idx, val);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] addr, logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (addr)
      CFG_GAMMA:  gamma_est = data;
      CFG_LAMBDA: lambda_est = data;
      CFG_ALPHA:  alpha_est = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (hold_off_cnt > 0) begin
      out_ready <= 1'b0;
      hold_off_cnt <= hold_off_cnt - 1;
    end else if (hold_off_req > 0) begin
      out_ready <= 1'b0;
      hold_off_cnt <= hold_off_req;
      hold_off_req <= 0;
    end else begin
      out_ready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 49) == 0 ? 1'b0 : 1'b0);
    end
  end

  always @(posedge clk) begin
    learn_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result reward=%0d td=%0d state=%0d", $time,
                 out_step_reward, out_td_error, out_state_index);
        mismatches++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_step_reward !== exp_res.reward) begin
          $display("%0t: step_reward expected %0d actual %0d", $time,
                   $signed(exp_res.reward), out_step_reward);
          mismatches++;
        end
        if (out_td_error !== exp_res.td_error) begin
          $display("%0t: td_error expected %0d actual %0d", $time,
                   $signed(exp_res.td_error), out_td_error);
          mismatches++;
        end
        if (out_state_index !== exp_res.state) begin
          $display("%0t: state_index expected %0d actual %0d", $time,
                   exp_res.state, out_state_index);
          mismatches++;
        end
      end
    end
  end

  task automatic test_start_and_load();
    send_request(REQ_START, 3'd0, 2'd0, 2'd0, 1'b0, 2'd0, 3'd0, 15'd0, 32'sd0);
    send_request(REQ_START, 3'd7, 2'd3, 2'd3, 1'b1, 2'd3, 3'd7, 15'h7fff, -32'sd1);
    send_request(REQ_LOAD, 3'd7, 2'd3, 2'd3, 1'b1, 2'd3, 3'd7, 15'd0, 32'sh7fffffff);
    send_request(REQ_LOAD, 3'd0, 2'd0, 2'd0, 1'b0, 2'd0, 3'd0, 15'd24999, 32'sh80000000);
    send_request(REQ_LOAD, 3'd0, 2'd0, 2'd0, 1'b0, 2'd0, 3'd0, 15'd25000, 32'sd12345);
    send_request(REQ_LOAD, 3'd0, 2'd0, 2'd0, 1'b0, 2'd0, 3'd0, 15'h7fff, 32'sd777);
    send_request(REQ_NONE, 3'd5, 2'd2, 2'd1, 1'b1, 2'd2, 3'd3, 15'd8, 32'sd99);
    send_request(REQ_START, 3'd2, 2'd1, 2'd1, 1'b1, 2'd0, 3'd0, 15'd0, 32'sd0);
    send_request(REQ_LOAD, 3'd0, 2'd0, 2'd0, 1'b0, 2'd0, 3'd0,
                 15'(encode_state(3'd2, 2'd1, 2'd1, 1'b1, 2'd0) * ACTION_COUNT), 32'sd200000);
  endtask

  task automatic test_steps();
    send_request(REQ_STEP, 3'd2, 2'd1, 2'd1, 1'b1, 2'd0, 3'd7, 15'd0, 32'sd0);
    send_request(REQ_STEP, 3'd0, 2'd2, 2'd2, 1'b1, 2'd1, 3'd0, 15'd0, 32'sd0);
    send_request(REQ_STEP, 3'd4, 2'd2, 2'd3, 1'b1, 2'd3, 3'd5, 15'd0, 32'sd0);
    send_request(REQ_STEP, 3'd3, 2'd0, 2'd1, 1'b1, 2'd2, 3'd1, 15'd0, 32'sd0);
    send_request(REQ_STEP, 3'd1, 2'd1, 2'd0, 1'b1, 2'd0, 3'd2, 15'd0, 32'sd0);
    send_request(REQ_STEP, 3'd3, 2'd2, 2'd2, 1'b0, 2'd1, 3'd6, 15'd0, 32'sd0);
    send_request(REQ_STEP, 3'd7, 2'd3, 2'd3, 1'b1, 2'd3, 3'd7, 15'd0, 32'sd0);
    send_request(REQ_START, 3'd2, 2'd1, 2'd1, 1'b1, 2'd0, 3'd0, 15'd0, 32'sd0);
    send_request(REQ_STEP, 3'd2, 2'd1, 2'd1, 1'b1, 2'd0, 3'd0, 15'd0, 32'sd0);
  endtask

  task automatic test_config();
    logic [15:0] gammas[3] = '{16'd0, 16'd65535, 16'd30000};
    logic [15:0] lambdas[3] = '{16'd65535, 16'd0, 16'd45000};
    logic [15:0] alphas[3] = '{16'd65535, 16'd0, 16'd1};
    for (int k = 0; k < 3; k++) begin
      wait_idle();
      write_cfg(CFG_GAMMA, gammas[k]);
      write_cfg(CFG_LAMBDA, lambdas[k]);
      write_cfg(CFG_ALPHA, alphas[k]);
      write_cfg(CFG_UNUSED, 16'hffff);
      send_request(REQ_LOAD, 3'd0, 2'd0, 2'd0, 1'b0, 2'd0, 3'd0,
                   15'(state_est * ACTION_COUNT + action_est), 32'sh7ff00000);
      send_request(REQ_STEP, 3'd2, 2'd1, 2'd1, 1'b1, 2'd0, 3'd3, 15'd0, 32'sd0);
      send_request(REQ_STEP, 3'd3, 2'd2, 2'd2, 1'b1, 2'd1, 3'd4, 15'd0, 32'sd0);
    end
    wait_idle();
    write_cfg(CFG_GAMMA, GAMMA_RST);
    write_cfg(CFG_LAMBDA, LAMBDA_RST);
    write_cfg(CFG_ALPHA, ALPHA_RST);
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_off_req = 300;
    for (int k = 0; k < 6; k++)
      send_request(REQ_LOAD, 3'd1, 2'd1, 2'd1, 1'b1, 2'd0, 3'd0, 15'($urandom_range(0, 24999)),
                   $urandom, 1);
    send_request(REQ_STEP, 3'd1, 2'd1, 2'd1, 1'b1, 2'd0, 3'd1, 15'd0, 32'sd0, 1);
    wait_idle();
  endtask

  task automatic test_random();
    for (int k = 0; k < 70; k++) send_random();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_start_and_load();
    test_steps();
    test_config();
    test_backpressure();
    test_random();
    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("sarsa_lambda_table_update verification clean");
    end else begin
      $display("sarsa_lambda_table_update verification failed");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("sarsa_lambda_table_update verification failed");
    $finish;
  end
endmodule
